FILE: rtl/mbd_pkg.sv
// Shared types and constants for the multi-button debounce / long-press unit.
// No dependencies; every other file refers to it by scoped names.
package mbd_pkg;

  localparam int unsigned BUTTONS = 16;
  localparam int unsigned BTN_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;

  // small queues between input, back end and result side
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CFG_DEBOUNCE    = 2'd0,
    CFG_LONG_PRESS  = 2'd1,
    CFG_IGNORE_MASK = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0]        button_index;
    logic              pressed_level;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0] event_button;
    logic       event_long;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
  } timing_cfg_t;

endpackage

FILE: rtl/mbd_front.sv
// Front end: accepts samples, drops ignored or out-of-range buttons and
// queues the rest for the back end. Depends on mbd_pkg.
module mbd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  mbd_pkg::in_item_t              in_item_i,
  input  logic [mbd_pkg::CFG_W-1:0]      ignore_mask_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output mbd_pkg::in_item_t              cmd_o
);

  mbd_pkg::in_item_t               entries_q [mbd_pkg::Q_DEPTH];
  logic [mbd_pkg::Q_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [mbd_pkg::Q_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [mbd_pkg::Q_CNT_W-1:0]     cnt_q, cnt_d;
  logic                            keep;
  logic                            wr_en;
  logic                            rd_en;

  assign full        = (cnt_q == mbd_pkg::Q_CNT_W'(mbd_pkg::Q_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = entries_q[rd_ptr_q];

  assign keep  = (32'(in_item_i.button_index) < 32'(mbd_pkg::BUTTONS)) &&
                 !ignore_mask_i[in_item_i.button_index];
  assign wr_en = push && !full && keep;
  assign rd_en = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == mbd_pkg::Q_PTR_W'(mbd_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == mbd_pkg::Q_PTR_W'(mbd_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entries_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

FILE: rtl/mbd_back.sv
// Back end: per-button debounce state, one read-modify-write per cycle unless
// its own release-item queue toward the result side is full. Depends on mbd_pkg.
module mbd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  mbd_pkg::in_item_t     cmd_i,
  input  mbd_pkg::timing_cfg_t  timing_cfg_i,
  output logic                  empty,
  input  logic                  pop,
  output mbd_pkg::out_item_t    out_item_o
);

  logic                         raw_q    [mbd_pkg::BUTTONS];
  logic                         stable_q [mbd_pkg::BUTTONS];
  logic                         seen_q   [mbd_pkg::BUTTONS];
  logic [mbd_pkg::TIME_W-1:0]   last_q   [mbd_pkg::BUTTONS];
  logic [mbd_pkg::TIME_W-1:0]   start_q  [mbd_pkg::BUTTONS];

  mbd_pkg::out_item_t           evq_q [mbd_pkg::Q_DEPTH];
  logic [mbd_pkg::Q_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [mbd_pkg::Q_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [mbd_pkg::Q_CNT_W-1:0]  cnt_q, cnt_d;

  logic [mbd_pkg::BTN_W-1:0]    btn;
  logic                         proc;
  logic                         lvl;
  logic [mbd_pkg::TIME_W-1:0]   now;
  logic                         raw_chg;
  logic [mbd_pkg::TIME_W-1:0]   last_eff;
  logic [mbd_pkg::TIME_W-1:0]   since_change;
  logic [mbd_pkg::TIME_W-1:0]   held_ms;
  logic                         settled;
  logic                         flip;
  logic                         rise;
  logic                         evt_push;
  logic                         evt_pop;
  mbd_pkg::out_item_t           evt;

  assign cmd_ready_o = (cnt_q != mbd_pkg::Q_CNT_W'(mbd_pkg::Q_DEPTH));
  assign proc        = cmd_valid_i && cmd_ready_o;
  assign btn         = mbd_pkg::BTN_W'(cmd_i.button_index);
  assign lvl         = cmd_i.pressed_level;
  assign now         = cmd_i.now_ms;

  // a raw change restarts the settle window at this sample's time
  assign raw_chg      = (lvl != raw_q[btn]);
  assign last_eff     = raw_chg ? now : last_q[btn];
  assign since_change = now - last_eff;
  assign settled      = (since_change >= mbd_pkg::TIME_W'(timing_cfg_i.debounce_time));
  assign flip         = settled && (stable_q[btn] != lvl);
  assign rise         = flip && !stable_q[btn];
  assign held_ms      = now - start_q[btn];

  // release only reports when the matching press was seen
  assign evt_push         = proc && flip && stable_q[btn] && seen_q[btn];
  assign evt.event_button = cmd_i.button_index;
  assign evt.event_long   = (held_ms >= mbd_pkg::TIME_W'(timing_cfg_i.long_press_time));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(mbd_pkg::BUTTONS); i++) begin
        raw_q[i]    <= 1'b0;
        stable_q[i] <= 1'b0;
        seen_q[i]   <= 1'b0;
        last_q[i]   <= '0;
        start_q[i]  <= '0;
      end
    end else if (proc) begin
      if (raw_chg) begin
        raw_q[btn]  <= lvl;
        last_q[btn] <= now;
      end
      if (flip) begin
        stable_q[btn] <= lvl;
        seen_q[btn]   <= rise;
        if (rise) begin
          start_q[btn] <= now;
        end
      end
    end
  end

  // release-item queue
  assign empty      = (cnt_q == '0);
  assign out_item_o = evq_q[rd_ptr_q];
  assign evt_pop    = pop && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (evt_push) begin
      wr_ptr_d = (wr_ptr_q == mbd_pkg::Q_PTR_W'(mbd_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (evt_pop) begin
      rd_ptr_d = (rd_ptr_q == mbd_pkg::Q_PTR_W'(mbd_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({evt_push, evt_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_push) begin
      evq_q[wr_ptr_q] <= evt;
    end
  end

endmodule

FILE: rtl/multi_button_debounce_long_press_unit.sv
// Multi-button debounce and long-press unit. One raw sample (button, level,
// millisecond time) is taken per clock; a new sample is accepted every cycle
// while full is low. The back end does one read-modify-write of the sample's
// button state entry and stalls while the release-item queue is full. A
// release item passes the front queue and then the release-item queue. Ignored
// and out-of-range buttons are dropped at the front and never reach the back
// end. Two-entry queues sit between front and back and on the result side; a
// full result queue stalls the back end, which in turn fills the input queue.
// Configuration writes are always ready and take effect on the next cycle.
// Depends on mbd_pkg, mbd_front and mbd_back.
module multi_button_debounce_long_press_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  mbd_pkg::in_item_t             in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output mbd_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index_i,
  input  logic [mbd_pkg::CFG_W-1:0]     cfg_data_i
);

  logic [mbd_pkg::CFG_W-1:0] debounce_q, debounce_d;
  logic [mbd_pkg::CFG_W-1:0] long_press_q, long_press_d;
  logic [mbd_pkg::CFG_W-1:0] ignore_mask_q, ignore_mask_d;
  mbd_pkg::timing_cfg_t      timing_cfg;
  logic                      cmd_valid;
  logic                      cmd_ready;
  mbd_pkg::in_item_t         cmd;

  assign cfg_ready = 1'b1;

  always_comb begin
    debounce_d    = debounce_q;
    long_press_d  = long_press_q;
    ignore_mask_d = ignore_mask_q;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index_i)
        mbd_pkg::CFG_DEBOUNCE:    debounce_d    = cfg_data_i;
        mbd_pkg::CFG_LONG_PRESS:  long_press_d  = cfg_data_i;
        mbd_pkg::CFG_IGNORE_MASK: ignore_mask_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= mbd_pkg::CFG_W'(30);
      long_press_q  <= mbd_pkg::CFG_W'(600);
      ignore_mask_q <= '0;
    end else begin
      debounce_q    <= debounce_d;
      long_press_q  <= long_press_d;
      ignore_mask_q <= ignore_mask_d;
    end
  end

  assign timing_cfg.debounce_time   = debounce_q;
  assign timing_cfg.long_press_time = long_press_q;

  mbd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_item_i     (in_item_i),
    .ignore_mask_i (ignore_mask_q),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  mbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .timing_cfg_i (timing_cfg),
    .empty        (empty),
    .pop          (pop),
    .out_item_o   (out_item_o)
  );

endmodule

FILE: rtl/mbd_checker.sv
// Port-level checks for the debounce unit, bound to the top level.
// Depends on mbd_pkg and multi_button_debounce_long_press_unit.
module mbd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input mbd_pkg::out_item_t out_item_o
);

  // reset leaves both queues drained
  assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("queues not drained during reset");

  // the input queue only fills because of an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !$past(full) |-> $past(push))
    else $error("full rose without an accepted item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("waiting result dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_item_o))
    else $error("waiting result changed");

endmodule

bind multi_button_debounce_long_press_unit mbd_checker u_chk (.*);

FILE: tb/tb_multi_button_debounce_long_press_unit.sv
`timescale 1ns / 100ps
// Testbench for multi_button_debounce_long_press_unit: samples go in, release items come out.
// A release tracker class predicts each release item. Depends on mbd_pkg and the unit itself.

class release_tracker;
  logic [mbd_pkg::CFG_W-1:0]  settle_ms;
  logic [mbd_pkg::CFG_W-1:0]  long_press_ms;
  logic [mbd_pkg::CFG_W-1:0]  ignore_bits;
  logic                       raw_lvl    [mbd_pkg::BUTTONS];
  logic                       stable_lvl [mbd_pkg::BUTTONS];
  logic                       pressed    [mbd_pkg::BUTTONS];
  logic [mbd_pkg::TIME_W-1:0] changed_at [mbd_pkg::BUTTONS];
  logic [mbd_pkg::TIME_W-1:0] pressed_at [mbd_pkg::BUTTONS];
  mbd_pkg::out_item_t         releases_due[$];
  int unsigned                errors;

  function new();
    settle_ms     = 16'd30;
    long_press_ms = 16'd600;
    ignore_bits   = '0;
    errors        = 0;
    for (int i = 0; i < mbd_pkg::BUTTONS; i++) begin
      raw_lvl[i]    = 1'b0;
      stable_lvl[i] = 1'b0;
      pressed[i]    = 1'b0;
      changed_at[i] = '0;
      pressed_at[i] = '0;
    end
  endfunction

  function void write_reg(logic [1:0] idx, logic [mbd_pkg::CFG_W-1:0] data);
    case (idx)
      mbd_pkg::CFG_DEBOUNCE:    settle_ms     = data;
      mbd_pkg::CFG_LONG_PRESS:  long_press_ms = data;
      mbd_pkg::CFG_IGNORE_MASK: ignore_bits   = data;
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return releases_due.size();
  endfunction

  function void note_sample(mbd_pkg::in_item_t s);
    logic [3:0]                 b;
    logic                       was_stable;
    logic [mbd_pkg::TIME_W-1:0] elapsed;
    mbd_pkg::out_item_t         rel;
    b = s.button_index;
    if (b >= mbd_pkg::BUTTONS || ignore_bits[b]) return;
    if (s.pressed_level != raw_lvl[b]) begin
      raw_lvl[b]    = s.pressed_level;
      changed_at[b] = s.now_ms;
    end
    elapsed = s.now_ms - changed_at[b];
    if (elapsed < {16'd0, settle_ms}) return;
    if (stable_lvl[b] == raw_lvl[b]) return;
    was_stable    = stable_lvl[b];
    stable_lvl[b] = raw_lvl[b];
    if (!was_stable) begin
      pressed[b]    = 1'b1;
      pressed_at[b] = s.now_ms;
      return;
    end
    if (!pressed[b]) return;
    pressed[b]       = 1'b0;
    elapsed          = s.now_ms - pressed_at[b];
    rel.event_button = s.button_index;
    rel.event_long   = (elapsed >= {16'd0, long_press_ms});
    releases_due.push_back(rel);
  endfunction

  function void check_release(mbd_pkg::out_item_t got);
    mbd_pkg::out_item_t want;
    if (releases_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected item: expected none, actual button=%0d long=%0b",
               $time, got.event_button, got.event_long);
      return;
    end
    want = releases_due.pop_front();
    if (got.event_button !== want.event_button) begin
      errors++;
      $display("%0t: event_button mismatch: expected %0d, actual %0d",
               $time, want.event_button, got.event_button);
    end
    if (got.event_long !== want.event_long) begin
      errors++;
      $display("%0t: event_long mismatch (button %0d): expected %0b, actual %0b",
               $time, want.event_button, want.event_long, got.event_long);
    end
  endfunction
endclass

module tb_multi_button_debounce_long_press_unit;

  localparam logic [1:0]  CFG_NO_REG    = 2'd3;  // no register behind this index
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 170;

  logic                       clk_i     = 1'b0;
  logic                       rst_ni    = 1'b0;
  logic                       push      = 1'b0;
  logic                       full;
  mbd_pkg::in_item_t          in_item   = '0;
  logic                       empty;
  logic                       pop       = 1'b0;
  mbd_pkg::out_item_t         out_item;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = '0;
  logic [mbd_pkg::CFG_W-1:0]  cfg_data  = '0;

  release_tracker             tracker;
  int unsigned                send_idle_pct = 32;
  int unsigned                recv_idle_pct = 86;
  int unsigned                db_cfg = 30;
  int unsigned                lp_cfg = 600;
  logic [mbd_pkg::CFG_W-1:0]  mask_cfg = '0;
  logic [mbd_pkg::TIME_W-1:0] cur_ms = 32'hFFFF_F000;
  logic [mbd_pkg::TIME_W-1:0] flip_at  [mbd_pkg::BUTTONS];
  logic                       want_lvl [mbd_pkg::BUTTONS];

  multi_button_debounce_long_press_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    pop = rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) tracker.note_sample(in_item);
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (pop && !empty) tracker.check_release(out_item);
    end
  end

  // called at a falling edge; returns at a falling edge with push still high
  task automatic send_sample(input logic [3:0] b, input logic lvl, input logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push                  = 1'b1;
    in_item.button_index  = b;
    in_item.pressed_level = lvl;
    in_item.now_ms        = t;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic settle();
    push = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    // items that cause no release may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [mbd_pkg::CFG_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setup(input int unsigned db, input int unsigned lp,
                             input logic [mbd_pkg::CFG_W-1:0] mask);
    settle();
    write_cfg(mbd_pkg::CFG_DEBOUNCE, db[mbd_pkg::CFG_W-1:0]);
    write_cfg(mbd_pkg::CFG_LONG_PRESS, lp[mbd_pkg::CFG_W-1:0]);
    write_cfg(mbd_pkg::CFG_IGNORE_MASK, mask);
    write_cfg(CFG_NO_REG, mbd_pkg::CFG_W'($urandom_range(16'hFFFF)));
    db_cfg   = db;
    lp_cfg   = lp;
    mask_cfg = mask;
  endtask

  // Mostly clean press/hold/release sequences on a few buttons, with bounce
  // and some samples carrying arbitrary buttons, levels and times.
  task automatic random_phase(input int unsigned n_items);
    logic [3:0]  active [3];
    logic [3:0]  b;
    logic        lvl;
    int unsigned step_max;
    int unsigned hold_max;
    step_max = ((db_cfg > lp_cfg) ? db_cfg : lp_cfg) / 6 + 2;
    hold_max = 2 * lp_cfg + 2 * db_cfg + 8;
    foreach (active[k]) begin
      do active[k] = 4'($urandom_range(15)); while (mask_cfg[active[k]]);
    end
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) settle();
      if ($urandom_range(99) < 8) begin
        send_sample(4'($urandom_range(15)), 1'($urandom_range(1)), $urandom());
      end else begin
        b = ($urandom_range(99) < 75) ? active[2'($urandom_range(2))]
                                      : 4'($urandom_range(15));
        cur_ms += $urandom_range(step_max);
        if ($signed(cur_ms - flip_at[b]) >= 0) begin
          want_lvl[b] = ~want_lvl[b];
          flip_at[b]  = cur_ms + $urandom_range(hold_max);
        end
        lvl = want_lvl[b] ^ ($urandom_range(99) < 10);
        send_sample(b, lvl, cur_ms);
      end
    end
  endtask

  initial begin
    tracker = new();
    foreach (flip_at[i]) begin
      flip_at[i]  = cur_ms;
      want_lvl[i] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset values: debounce 30, long press 600
    send_sample(4'd0, 1'b1, 32'd100);
    send_sample(4'd0, 1'b1, 32'd130);          // press after exactly the debounce time
    send_sample(4'd0, 1'b0, 32'd200);
    send_sample(4'd0, 1'b0, 32'd229);          // one ms short of debounce
    send_sample(4'd0, 1'b0, 32'd230);          // short release
    send_sample(4'd15, 1'b1, 32'd1000);
    send_sample(4'd15, 1'b1, 32'd1030);
    send_sample(4'd15, 1'b0, 32'd1600);
    send_sample(4'd15, 1'b0, 32'd1630);        // held exactly the long-press time
    send_sample(4'd9, 1'b1, 32'd2000);
    send_sample(4'd9, 1'b1, 32'd2030);
    send_sample(4'd9, 1'b0, 32'd2599);
    send_sample(4'd9, 1'b0, 32'd2629);         // one ms short of long
    send_sample(4'd3, 1'b1, 32'hFFFF_FFF0);
    send_sample(4'd3, 1'b1, 32'h0000_000E);    // press across the time wrap
    send_sample(4'd3, 1'b0, 32'h0000_0300);
    send_sample(4'd3, 1'b0, 32'h0000_031E);
    send_sample(4'd4, 1'b1, 32'd3000);         // bouncing contact
    send_sample(4'd4, 1'b0, 32'd3010);
    send_sample(4'd4, 1'b1, 32'd3020);
    send_sample(4'd4, 1'b1, 32'd3049);

    apply_setup(0, 0, 16'h7FFF);
    send_sample(4'd4, 1'b1, 32'd3100);         // masked button
    send_sample(4'd15, 1'b1, 32'd5000);        // zero debounce: immediate press
    send_sample(4'd15, 1'b0, 32'd5000);        // zero hold counts as long

    apply_setup(65535, 65535, 16'h0000);
    send_sample(4'd4, 1'b1, 32'd68555);
    send_sample(4'd4, 1'b0, 32'd70000);
    send_sample(4'd4, 1'b0, 32'd135535);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_setup(30, 600, 16'h0000);
        1: apply_setup(0, 0, 16'h8001);
        2: apply_setup($urandom_range(1, 300), $urandom_range(0, 3000),
                       mbd_pkg::CFG_W'($urandom() & $urandom() & $urandom()));
        3: apply_setup(65535, 65535, 16'h0000);
        4: apply_setup($urandom_range(0, 65535), $urandom_range(0, 65535),
                       mbd_pkg::CFG_W'($urandom() & $urandom()));
        default: apply_setup(65535, 0, 16'h0FF0);
      endcase
      if (ph < 2) begin
        send_idle_pct = 32;
        recv_idle_pct = 86;
      end else if (ph < 4) begin
        send_idle_pct = 86;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_phase(PHASE_ITEMS);
    end

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: multi_button_debounce_long_press_unit.f
rtl/mbd_pkg.sv
rtl/mbd_front.sv
rtl/mbd_back.sv
rtl/multi_button_debounce_long_press_unit.sv
rtl/mbd_checker.sv
tb/tb_multi_button_debounce_long_press_unit.sv
